// File: rtl/core/swsc_pkg.sv
package swsc_pkg;

  // Sequence space and send window of the sender.
  localparam int unsigned SeqSpace  = 8;
  localparam int unsigned Window    = 4;
  localparam int unsigned EffWindow = (Window < SeqSpace) ? Window : SeqSpace;

  // Widths of sequence numbers and of the outstanding-packet count.
  localparam int unsigned SeqW = (SeqSpace > 2) ? $clog2(SeqSpace) : 1;
  localparam int unsigned CntW = $clog2(SeqSpace + 1);
  localparam int unsigned AckW = 3;

  typedef logic [SeqW-1:0] seq_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [AckW-1:0] ack_t;

  // Event codes carried by an input transfer.
  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Status codes carried by a result transfer.
  typedef enum logic [2:0] {
    ST_SENT      = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_SLID      = 3'd2,
    ST_DUP       = 3'd3,
    ST_FAST_RTX  = 3'd4,
    ST_BAD_CKSUM = 3'd5,
    ST_TIMEOUT   = 3'd6
  } status_e;

  // Sender window state.
  typedef struct packed {
    seq_t       window_base;
    seq_t       next_seq;
    logic       waiting;
    logic [1:0] dup_count;
    ack_t       dup_ack_value;
  } state_t;

  // One result of the sender.
  typedef struct packed {
    status_e status;
    logic    packet_valid;
    seq_t    packet_seq;
    logic    timer_stop;
    seq_t    stop_seq;
    logic    timer_start;
    seq_t    start_seq;
    logic    window_full;
  } result_t;

  // Distance from b forward to a, modulo the sequence space.
  function automatic seq_t mod_dist(seq_t a, seq_t b);
    logic [SeqW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[SeqW]) begin
      d = d + (SeqW+1)'(SeqSpace);
    end
    return d[SeqW-1:0];
  endfunction

  // Next sequence number, wrapping at the end of the sequence space.
  function automatic seq_t seq_incr(seq_t a);
    seq_t r;
    if ({1'b0, a} == (SeqW+1)'(SeqSpace - 1)) begin
      r = '0;
    end else begin
      r = a + SeqW'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/swsc_in_if.sv
interface swsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] ack_number;
  logic       checksum_ok;
  logic [2:0] expired_seq;

  modport source (output valid, op, ack_number, checksum_ok, expired_seq, input ready);
  modport sink (input valid, op, ack_number, checksum_ok, expired_seq, output ready);
endinterface

// File: rtl/core/swsc_out_if.sv
interface swsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       packet_valid;
  logic [2:0] packet_seq;
  logic       timer_stop;
  logic [2:0] stop_seq;
  logic       timer_start;
  logic [2:0] start_seq;
  logic       window_full;

  modport source (
    output valid, status, packet_valid, packet_seq, timer_stop, stop_seq,
           timer_start, start_seq, window_full,
    input  ready
  );
  modport sink (
    input  valid, status, packet_valid, packet_seq, timer_stop, stop_seq,
           timer_start, start_seq, window_full,
    output ready
  );
endinterface

// File: rtl/core/swsc_step.sv
module swsc_step import swsc_pkg::*; (
  input  state_t     state_i,
  input  op_e        op_i,
  input  ack_t       ack_number_i,
  input  logic       checksum_ok_i,
  input  ack_t       expired_seq_i,
  output state_t     state_o,
  output result_t    result_o
);

  cnt_t cnt;
  cnt_t ack_dist;
  seq_t ack_seq;
  seq_t base_next;
  logic ack_in_space;
  logic ack_in_window;
  logic more_left;

  // Outstanding count and position of the acknowledgement in the window.
  always_comb begin
    cnt          = state_i.waiting ? CntW'(EffWindow)
                                   : CntW'(mod_dist(state_i.next_seq, state_i.window_base));
    ack_in_space = (CntW'(ack_number_i) < CntW'(SeqSpace));
    ack_seq      = SeqW'(ack_number_i);
    ack_dist     = CntW'(mod_dist(ack_seq, state_i.window_base));
    ack_in_window = ack_in_space && (ack_dist < cnt);
    more_left    = ((ack_dist + CntW'(1)) < cnt);
    base_next    = seq_incr(ack_seq);
  end

  // Event handling: next state and the result of this event.
  always_comb begin
    state_o  = state_i;
    result_o = '{status: ST_BAD_CKSUM, default: '0};

    unique case (op_i)
      OP_SEND: begin
        if (state_i.waiting) begin
          result_o.status = ST_REFUSED;
        end else begin
          if (cnt == CntW'(EffWindow - 1)) begin
            state_o.waiting = 1'b1;
          end
          if (cnt == '0) begin
            result_o.timer_start = 1'b1;
            result_o.start_seq   = state_i.next_seq;
          end
          result_o.packet_valid = 1'b1;
          result_o.packet_seq   = state_i.next_seq;
          state_o.next_seq      = seq_incr(state_i.next_seq);
          result_o.status       = ST_SENT;
        end
      end
      OP_ACK: begin
        priority if (!checksum_ok_i) begin
          result_o.status = ST_BAD_CKSUM;
        end else if (ack_in_window) begin
          result_o.timer_stop = 1'b1;
          result_o.stop_seq   = state_i.window_base;
          state_o.window_base = base_next;
          if (more_left) begin
            result_o.timer_start = 1'b1;
            result_o.start_seq   = base_next;
          end
          state_o.waiting = 1'b0;
          result_o.status = ST_SLID;
        end else if (ack_number_i == state_i.dup_ack_value) begin
          if (state_i.dup_count == 2'd2) begin
            state_o.dup_count = '0;
            if (cnt != '0) begin
              result_o.timer_stop   = 1'b1;
              result_o.stop_seq     = state_i.window_base;
              result_o.timer_start  = 1'b1;
              result_o.start_seq    = state_i.window_base;
              result_o.packet_valid = 1'b1;
              result_o.packet_seq   = state_i.window_base;
              result_o.status       = ST_FAST_RTX;
            end else begin
              result_o.status = ST_DUP;
            end
          end else begin
            state_o.dup_count = state_i.dup_count + 2'd1;
            result_o.status   = ST_DUP;
          end
        end else begin
          state_o.dup_ack_value = ack_number_i;
          state_o.dup_count     = 2'd1;
          result_o.status       = ST_DUP;
        end
      end
      OP_TIMEOUT: begin
        result_o.timer_stop = 1'b1;
        result_o.stop_seq   = SeqW'(expired_seq_i);
        if (cnt != '0) begin
          result_o.timer_start  = 1'b1;
          result_o.start_seq    = SeqW'(expired_seq_i);
          result_o.packet_valid = 1'b1;
          result_o.packet_seq   = state_i.window_base;
        end
        result_o.status = ST_TIMEOUT;
      end
      OP_NONE: begin
        result_o.status = ST_BAD_CKSUM;
      end
      default: begin
        result_o.status = ST_BAD_CKSUM;
      end
    endcase

    result_o.window_full = state_o.waiting;
  end

endmodule

// File: rtl/core/sliding_window_sender_control.sv
// Go-back-N sender control with fast retransmit. Each input transfer is one
// event (send request, acknowledgement or timer expiry) and yields exactly one
// result transfer that names the packet to send or resend, the timer to stop,
// the timer to start and the window-full flag. An event is captured in an
// input register, evaluated against the window state and stored in a result
// register, so a new event is taken every cycle unless the output stalls. The
// result is offered once the event moves from the input register into the
// result register. The window state updates as the event moves into the result
// register, so back to back events always see the state left by the event
// before them. Output backpressure stalls both stages; nothing is dropped.
module sliding_window_sender_control import swsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  swsc_in_if.sink    req_i,
  swsc_out_if.source res_o
);

  logic    req_valid_q;
  op_e     op_q;
  ack_t    ack_number_q;
  logic    checksum_ok_q;
  ack_t    expired_seq_q;

  state_t  state_q;
  state_t  state_d;
  result_t result_d;
  result_t res_q;
  logic    res_valid_q;

  logic    advance;
  logic    req_ready;

  // An event moves on when the result register is free or being emptied.
  assign advance   = req_valid_q && (!res_valid_q || res_o.ready);
  assign req_ready = !req_valid_q || advance;
  assign req_i.ready = req_ready;

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  // Input register payload, loaded on each input transfer.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_ready) begin
      op_q          <= op_e'(req_i.op);
      ack_number_q  <= req_i.ack_number;
      checksum_ok_q <= req_i.checksum_ok;
      expired_seq_q <= req_i.expired_seq;
    end
  end

  swsc_step u_step (
    .state_i       (state_q),
    .op_i          (op_q),
    .ack_number_i  (ack_number_q),
    .checksum_ok_i (checksum_ok_q),
    .expired_seq_i (expired_seq_q),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  // Window state and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= result_d;
    end
  end

  // Result channel.
  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_q.status;
  assign res_o.packet_valid = res_q.packet_valid;
  assign res_o.packet_seq   = res_q.packet_seq;
  assign res_o.timer_stop   = res_q.timer_stop;
  assign res_o.stop_seq     = res_q.stop_seq;
  assign res_o.timer_start  = res_q.timer_start;
  assign res_o.start_seq    = res_q.start_seq;
  assign res_o.window_full  = res_q.window_full;

endmodule

// File: tb/sv/sliding_window_sender_control_tb.sv
`timescale 1ns / 100ps

module sliding_window_sender_control_tb;
  import swsc_pkg::*;

  // Tracks the sender window from accepted events and predicts each result.
  class sender_window_tracker;
    seq_t       base_seq;
    seq_t       send_seq;
    logic       full_flag;
    logic [1:0] dup_run;
    ack_t       dup_value;
    result_t    expected_results[$];
    int         mismatches;

    function new();
      base_seq   = '0;
      send_seq   = '0;
      full_flag  = 1'b0;
      dup_run    = '0;
      dup_value  = '0;
      mismatches = 0;
    endfunction

    function int unsigned seq_distance(int unsigned a, int unsigned b);
      return (a + SeqSpace - b) % SeqSpace;
    endfunction

    // Packets sent but not yet acknowledged.
    function int unsigned in_flight();
      return full_flag ? EffWindow : seq_distance(send_seq, base_seq);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Applies one accepted event to the window and queues its result.
    function void note_event(logic [1:0] op, ack_t ack, logic ck, seq_t expired);
      result_t     r;
      int unsigned cnt;
      int unsigned ack_offset;
      cnt = in_flight();
      r = '0;
      r.status = ST_BAD_CKSUM;
      case (op)
        OP_SEND: begin
          if (full_flag) begin
            r.status = ST_REFUSED;
          end else begin
            if (cnt == EffWindow - 1) full_flag = 1'b1;
            // The first packet in an empty window starts the timer.
            if (cnt == 0) begin
              r.timer_start = 1'b1;
              r.start_seq   = send_seq;
            end
            r.packet_valid = 1'b1;
            r.packet_seq   = send_seq;
            send_seq = seq_t'((send_seq + 1) % SeqSpace);
            r.status = ST_SENT;
          end
        end
        OP_ACK: begin
          ack_offset = seq_distance(ack, base_seq);
          if (!ck) begin
            r.status = ST_BAD_CKSUM;
          end else if (ack < SeqSpace && ack_offset < cnt) begin
            // Cumulative acknowledgement slides the base past the acked packet.
            r.timer_stop = 1'b1;
            r.stop_seq   = base_seq;
            base_seq = seq_t'((ack + 1) % SeqSpace);
            if (cnt - ack_offset - 1 > 0) begin
              r.timer_start = 1'b1;
              r.start_seq   = base_seq;
            end
            full_flag = 1'b0;
            r.status  = ST_SLID;
          end else if (ack == dup_value) begin
            if (dup_run == 2'd2) begin
              dup_run = '0;
              if (cnt > 0) begin
                r.timer_stop   = 1'b1;
                r.stop_seq     = base_seq;
                r.timer_start  = 1'b1;
                r.start_seq    = base_seq;
                r.packet_valid = 1'b1;
                r.packet_seq   = base_seq;
                r.status       = ST_FAST_RTX;
              end else begin
                r.status = ST_DUP;
              end
            end else begin
              dup_run  = dup_run + 2'd1;
              r.status = ST_DUP;
            end
          end else begin
            // A different out-of-window number restarts the duplicate run.
            dup_value = ack;
            dup_run   = 2'd1;
            r.status  = ST_DUP;
          end
        end
        OP_TIMEOUT: begin
          r.timer_stop = 1'b1;
          r.stop_seq   = expired;
          if (cnt > 0) begin
            r.timer_start  = 1'b1;
            r.start_seq    = expired;
            r.packet_valid = 1'b1;
            r.packet_seq   = base_seq;
          end
          r.status = ST_TIMEOUT;
        end
        default: ;
      endcase
      r.window_full = full_flag;
      expected_results.insert(expected_results.size(), r);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Compares one result transfer with the oldest expectation.
    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, status", got.status, -1);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.packet_valid !== want.packet_valid)
          report_mismatch("packet_valid", got.packet_valid, want.packet_valid);
        if (got.packet_seq !== want.packet_seq)
          report_mismatch("packet_seq", got.packet_seq, want.packet_seq);
        if (got.timer_stop !== want.timer_stop)
          report_mismatch("timer_stop", got.timer_stop, want.timer_stop);
        if (got.stop_seq !== want.stop_seq)
          report_mismatch("stop_seq", got.stop_seq, want.stop_seq);
        if (got.timer_start !== want.timer_start)
          report_mismatch("timer_start", got.timer_start, want.timer_start);
        if (got.start_seq !== want.start_seq)
          report_mismatch("start_seq", got.start_seq, want.start_seq);
        if (got.window_full !== want.window_full)
          report_mismatch("window_full", got.window_full, want.window_full);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  swsc_in_if  req_if ();
  swsc_out_if res_if ();

  sliding_window_sender_control dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  sender_window_tracker window_sb = new();

  bit calm_phase;
  bit hold_request;
  int hold_left;

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Overall time limit.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Result side: checks each transfer and throttles ready.
  initial begin
    hold_left = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        window_sb.check_result('{
          status:       status_e'(res_if.status),
          packet_valid: res_if.packet_valid,
          packet_seq:   res_if.packet_seq,
          timer_stop:   res_if.timer_stop,
          stop_seq:     res_if.stop_seq,
          timer_start:  res_if.timer_start,
          start_seq:    res_if.start_seq,
          window_full:  res_if.window_full
        });
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 80;
        res_if.ready <= 1'b0;
      end else if (calm_phase) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // Offers one event and waits for its transfer; valid sometimes drops afterward.
  task automatic offer_event(logic [1:0] op, ack_t ack, logic ck, seq_t expired);
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.ack_number  <= ack;
    req_if.checksum_ok <= ck;
    req_if.expired_seq <= expired;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    window_sb.note_event(op, ack, ck, expired);
    if (!calm_phase && $urandom_range(99) < 32) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  // Random event, biased toward acknowledgements that land in the window
  // and repeats that build up a duplicate run.
  task automatic random_event(output bit counted);
    int unsigned pick;
    int unsigned cnt;
    ack_t        ack;
    seq_t        expired;
    logic        ck;
    pick = $urandom_range(99);
    cnt = window_sb.in_flight();
    ack = ack_t'($urandom_range(7));
    ck = ($urandom_range(15) != 0);
    expired = seq_t'($urandom_range(7));
    counted = 1'b1;
    if (pick < 40) begin
      offer_event(OP_SEND, ack, ck, expired);
    end else if (pick < 72) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          if (cnt > 0) ack = ack_t'((window_sb.base_seq + $urandom_range(cnt - 1)) % SeqSpace);
        end
        6, 7, 8: ack = window_sb.dup_value;
        default: ;
      endcase
      offer_event(OP_ACK, ack, ck, expired);
    end else if (pick < 96) begin
      if ($urandom_range(3) != 0) expired = window_sb.base_seq;
      offer_event(OP_TIMEOUT, ack, ck, expired);
    end else begin
      counted = 1'b0;
      offer_event(OP_NONE, ack, ck, expired);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    int  n_events;
    bit  counted;
    rst_ni = 1'b0;
    calm_phase = 1'b0;
    hold_request = 1'b0;
    req_if.valid       <= 1'b0;
    req_if.op          <= OP_SEND;
    req_if.ack_number  <= '0;
    req_if.checksum_ok <= 1'b0;
    req_if.expired_seq <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Fill the window, get refused, then time out, which resends the oldest packet.
    offer_event(OP_SEND, 3'd0, 1'b0, 3'd0);
    offer_event(OP_SEND, 3'd7, 1'b1, 3'd7);
    offer_event(OP_SEND, 3'd0, 1'b0, 3'd0);
    offer_event(OP_SEND, 3'd0, 1'b0, 3'd0);
    offer_event(OP_SEND, 3'd0, 1'b0, 3'd0);
    offer_event(OP_TIMEOUT, 3'd0, 1'b0, 3'd7);
    // Bad checksum is dropped even when the number is in the window.
    offer_event(OP_ACK, 3'd1, 1'b0, 3'd0);
    offer_event(OP_ACK, 3'd1, 1'b1, 3'd0);
    // Three repeats of an out-of-window number trigger a fast retransmit.
    offer_event(OP_ACK, 3'd7, 1'b1, 3'd0);
    offer_event(OP_ACK, 3'd7, 1'b1, 3'd0);
    offer_event(OP_ACK, 3'd7, 1'b1, 3'd0);
    offer_event(OP_NONE, 3'd7, 1'b1, 3'd7);
    // Drain the window; timeout and duplicates with nothing outstanding.
    offer_event(OP_ACK, 3'd3, 1'b1, 3'd0);
    offer_event(OP_TIMEOUT, 3'd7, 1'b1, 3'd0);
    offer_event(OP_ACK, 3'd0, 1'b1, 3'd0);
    offer_event(OP_ACK, 3'd0, 1'b1, 3'd0);
    offer_event(OP_ACK, 3'd0, 1'b1, 3'd0);
    // Wrap the sequence numbers around the end of the space.
    offer_event(OP_SEND, 3'd0, 1'b0, 3'd0);
    offer_event(OP_SEND, 3'd0, 1'b0, 3'd0);
    offer_event(OP_SEND, 3'd0, 1'b0, 3'd0);
    offer_event(OP_SEND, 3'd0, 1'b0, 3'd0);
    offer_event(OP_ACK, 3'd5, 1'b1, 3'd0);
    offer_event(OP_SEND, 3'd0, 1'b0, 3'd0);
    offer_event(OP_ACK, 3'd0, 1'b1, 3'd0);

    n_events = 0;
    while (n_events < 1150) begin
      calm_phase = (n_events >= 300 && n_events < 450);
      if (n_events == 600) hold_request = 1'b1;
      if (n_events == 800) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (window_sb.pending() != 0) @(posedge clk_i);
      end
      random_event(counted);
      if (counted) n_events++;
    end
    calm_phase = 1'b0;
    req_if.valid <= 1'b0;

    while (window_sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (window_sb.mismatches == 0 && window_sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
